// File: rtl/gfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared types, op codes and saturating helpers for the force accumulator.
// ----------------------------------------------------------------------------
package gfa_pkg;

  localparam int OP_W = 5;

  localparam logic [OP_W-1:0] OP_MUL_AA   = 5'd0;
  localparam logic [OP_W-1:0] OP_MUL_BB   = 5'd1;
  localparam logic [OP_W-1:0] OP_SQRT_R   = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV_UX   = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV_UY   = 5'd4;
  localparam logic [OP_W-1:0] OP_MUL_RR   = 5'd5;
  localparam logic [OP_W-1:0] OP_MUL_GM   = 5'd6;
  localparam logic [OP_W-1:0] OP_MUL_GMM  = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV_M    = 5'd8;
  localparam logic [OP_W-1:0] OP_MUL_MX   = 5'd9;
  localparam logic [OP_W-1:0] OP_MUL_MY   = 5'd10;
  localparam logic [OP_W-1:0] OP_MUL_XX   = 5'd11;
  localparam logic [OP_W-1:0] OP_MUL_YY   = 5'd12;
  localparam logic [OP_W-1:0] OP_MUL_LL   = 5'd13;
  localparam logic [OP_W-1:0] OP_SQRT_MAG = 5'd14;
  localparam logic [OP_W-1:0] OP_MUL_XL   = 5'd15;
  localparam logic [OP_W-1:0] OP_DIV_X    = 5'd16;
  localparam logic [OP_W-1:0] OP_MUL_YL   = 5'd17;
  localparam logic [OP_W-1:0] OP_DIV_Y    = 5'd18;

  localparam logic [1:0] UNIT_MUL  = 2'd0;
  localparam logic [1:0] UNIT_SQRT = 2'd1;
  localparam logic [1:0] UNIT_DIV  = 2'd2;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 8'd1;

  localparam logic [31:0] GRAV_RESET  = 32'd437377302;
  localparam logic [39:0] LIMIT_RESET = 40'd100000;

  localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S48 = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] MIN_M48 = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic            load;
    logic            start;
    logic [OP_W-1:0] op;
    logic            emit;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic pair_zero;
    logic last;
    logic clamped;
    logic out_free;
  } dp_stat_t;

  function automatic logic [1:0] op_unit(input logic [OP_W-1:0] op);
    logic [1:0] u;
    case (op)
      OP_SQRT_R, OP_SQRT_MAG: u = UNIT_SQRT;
      OP_DIV_UX, OP_DIV_UY, OP_DIV_M, OP_DIV_X, OP_DIV_Y: u = UNIT_DIV;
      default: u = UNIT_MUL;
    endcase
    return u;
  endfunction

  // floor(p / 2^32) saturated to the positive signed 64-bit range
  function automatic logic [63:0] scale_unit(input logic [127:0] p);
    logic [63:0] v;
    v = p[95:32];
    if (p[127:96] != 32'd0 || v[63]) begin
      v = MAX_S64;
    end
    return v;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [63:0] c,
                                          input logic neg);
    logic [64:0] r;
    logic [63:0] o;
    if (neg) begin
      r = {acc[63], acc} - {1'b0, c};
    end else begin
      r = {acc[63], acc} + {1'b0, c};
    end
    o = r[63:0];
    if (r[64] != r[63]) begin
      o = neg ? MIN_S64 : MAX_S64;
    end
    return o;
  endfunction

  function automatic logic [47:0] out48(input logic [63:0] m, input logic neg);
    logic [63:0] mm;
    logic [47:0] o;
    if (neg) begin
      mm = (m > MIN_M48) ? MIN_M48 : m;
      o = 48'd0 - mm[47:0];
    end else begin
      mm = (m > MAX_S48) ? MAX_S48 : m;
      o = mm[47:0];
    end
    return o;
  endfunction

endpackage

// File: rtl/gfa_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_controller
// Sequences the per-pair and final clamp operations on the shared datapath.
// ----------------------------------------------------------------------------
module gfa_controller import gfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_CHK    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]      state;
  logic [OP_W-1:0] op;
  logic            start;

  function automatic logic [OP_W-1:0] next_op(input logic [OP_W-1:0] o);
    logic [OP_W-1:0] n;
    case (o)
      OP_MUL_AA:   n = OP_MUL_BB;
      OP_MUL_BB:   n = OP_SQRT_R;
      OP_SQRT_R:   n = OP_DIV_UX;
      OP_DIV_UX:   n = OP_DIV_UY;
      OP_DIV_UY:   n = OP_MUL_RR;
      OP_MUL_RR:   n = OP_MUL_GM;
      OP_MUL_GM:   n = OP_MUL_GMM;
      OP_MUL_GMM:  n = OP_DIV_M;
      OP_DIV_M:    n = OP_MUL_MX;
      OP_MUL_MX:   n = OP_MUL_MY;
      OP_MUL_XX:   n = OP_MUL_YY;
      OP_MUL_YY:   n = OP_MUL_LL;
      OP_SQRT_MAG: n = OP_MUL_XL;
      OP_MUL_XL:   n = OP_DIV_X;
      OP_DIV_X:    n = OP_MUL_YL;
      OP_MUL_YL:   n = OP_DIV_Y;
      default:     n = o;
    endcase
    return n;
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign cmd.load  = (state == ST_IDLE) && in_valid;
  assign cmd.start = start;
  assign cmd.op    = op;
  assign cmd.emit  = (state == ST_EMIT) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_MUL_AA;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!stat.pair_zero) begin
            op    <= OP_MUL_AA;
            start <= 1'b1;
            state <= ST_RUN;
          end else if (stat.last) begin
            op    <= OP_MUL_XX;
            start <= 1'b1;
            state <= ST_RUN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (stat.done) begin
            case (op)
              OP_MUL_MY: begin
                if (stat.last) begin
                  op    <= OP_MUL_XX;
                  start <= 1'b1;
                end else begin
                  state <= ST_IDLE;
                end
              end
              OP_MUL_LL: state <= ST_CHK;
              OP_DIV_Y:  state <= ST_EMIT;
              default: begin
                op    <= next_op(op);
                start <= 1'b1;
              end
            endcase
          end
        end
        ST_CHK: begin
          if (stat.clamped) begin
            op    <= OP_SQRT_MAG;
            start <= 1'b1;
            state <= ST_RUN;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_datapath
// Operand registers, shared 64x64 multiplier, square root and divider units.
// ----------------------------------------------------------------------------
module gfa_datapath import gfa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic signed [31:0]   self_x,
  input  logic signed [31:0]   self_y,
  input  logic        [23:0]   self_mass,
  input  logic signed [31:0]   other_x,
  input  logic signed [31:0]   other_y,
  input  logic        [23:0]   other_mass,
  input  logic                 last_body,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [47:0]   force_x,
  output logic signed [47:0]   force_y,
  output logic                 was_clamped
);

  // config
  logic [31:0] grav;
  logic [39:0] limit;

  // latched pair
  logic [31:0] a, b;
  logic        s, dneg, eneg, pz, last;
  logic [23:0] m1, m2;

  // intermediate values
  logic [63:0]  r, ux, uy, den, gm, m, mag, mx, my;
  logic [63:0]  sx, sy;
  logic [127:0] t, t2;
  logic         clamped;

  // unit control
  logic       busy, fin;
  logic [5:0] cnt;
  logic [1:0] unit;

  // multiplier
  logic [63:0]  ma, mb;
  logic [127:0] acc;
  logic [31:0]  ha, hb;
  logic [63:0]  pp;
  logic [6:0]   shamt;

  // square root
  logic [127:0] rad;
  logic [67:0]  srem;
  logic [63:0]  root;
  logic [67:0]  srem2, trial;
  logic         sge;

  // divider
  logic [63:0] drem, dnl, dd, quo;
  logic        dsat;
  logic [64:0] drem2;
  logic        dge;

  // load-time difference logic
  logic [32:0] dx33, dy33, adx, ady;
  logic        s_in;

  // operand select
  logic [63:0]  sel_ma, sel_mb, sel_dd;
  logic [127:0] sel_rad, sel_n;
  logic [63:0]  ax, ay, lim, div_res, root_g;

  assign dx33 = {self_x[31], self_x} - {other_x[31], other_x};
  assign dy33 = {self_y[31], self_y} - {other_y[31], other_y};
  assign adx  = dx33[32] ? 33'd0 - dx33 : dx33;
  assign ady  = dy33[32] ? 33'd0 - dy33 : dy33;
  assign s_in = |(adx[32:31] | ady[32:31]);

  assign ax  = sx[63] ? 64'd0 - sx : sx;
  assign ay  = sy[63] ? 64'd0 - sy : sy;
  assign lim = 64'(limit) << FRAC_BITS;

  assign unit = op_unit(cmd.op);

  always_comb begin
    sel_ma  = 64'd0;
    sel_mb  = 64'd0;
    sel_rad = t;
    sel_n   = t2;
    sel_dd  = mag;
    case (cmd.op)
      OP_MUL_AA:  begin sel_ma = 64'(a);    sel_mb = 64'(a);  end
      OP_MUL_BB:  begin sel_ma = 64'(b);    sel_mb = 64'(b);  end
      OP_MUL_RR:  begin sel_ma = r;         sel_mb = r;       end
      OP_MUL_GM:  begin sel_ma = 64'(grav); sel_mb = 64'(m1); end
      OP_MUL_GMM: begin sel_ma = gm;        sel_mb = 64'(m2); end
      OP_MUL_MX:  begin sel_ma = m;         sel_mb = ux;      end
      OP_MUL_MY:  begin sel_ma = m;         sel_mb = uy;      end
      OP_MUL_XX:  begin sel_ma = ax;        sel_mb = ax;      end
      OP_MUL_YY:  begin sel_ma = ay;        sel_mb = ay;      end
      OP_MUL_LL:  begin sel_ma = lim;       sel_mb = lim;     end
      OP_MUL_XL:  begin sel_ma = ax;        sel_mb = lim;     end
      OP_MUL_YL:  begin sel_ma = ay;        sel_mb = lim;     end
      OP_DIV_UX:  begin sel_n = {64'd0, a, 32'd0}; sel_dd = r; end
      OP_DIV_UY:  begin sel_n = {64'd0, b, 32'd0}; sel_dd = r; end
      OP_DIV_M:   begin sel_n = t;  sel_dd = den; end
      default: begin
      end
    endcase
  end

  // partial product of one 32-bit half from each operand per cycle
  assign ha    = cnt[1] ? ma[63:32] : ma[31:0];
  assign hb    = cnt[0] ? mb[63:32] : mb[31:0];
  assign pp    = ha * hb;
  assign shamt = {cnt[1] & cnt[0], cnt[1] ^ cnt[0], 5'd0};

  assign srem2 = {srem[65:0], rad[127:126]};
  assign trial = {2'b00, root, 2'b01};
  assign sge   = (srem2 >= trial);

  assign drem2 = {drem, dnl[63]};
  assign dge   = (drem2 >= {1'b0, dd});

  assign div_res = dsat ? {64{1'b1}} : quo;
  assign root_g  = (root == 64'd0) ? 64'd1 : root;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav      <= GRAV_RESET;
      limit     <= LIMIT_RESET;
      busy      <= 1'b0;
      fin       <= 1'b0;
      cnt       <= 6'd0;
      out_valid <= 1'b0;
      sx        <= 64'd0;
      sy        <= 64'd0;
    end else begin
      fin <= 1'b0;

      if (cfg_valid) begin
        if (cfg_index == CFG_GRAV) begin
          grav <= cfg_data[31:0];
        end else if (cfg_index == CFG_LIMIT) begin
          limit <= cfg_data;
        end
      end

      if (cmd.load) begin
        s    <= s_in;
        a    <= s_in ? adx[32:1] : adx[31:0];
        b    <= s_in ? ady[32:1] : ady[31:0];
        dneg <= dx33[32];
        eneg <= dy33[32];
        pz   <= (dx33 == 33'd0) && (dy33 == 33'd0);
        m1   <= self_mass;
        m2   <= other_mass;
        last <= last_body;
      end

      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        ma   <= sel_ma;
        mb   <= sel_mb;
        acc  <= 128'd0;
        rad  <= sel_rad;
        srem <= 68'd0;
        root <= 64'd0;
        drem <= sel_n[127:64];
        dnl  <= sel_n[63:0];
        dd   <= sel_dd;
        dsat <= (sel_n[127:64] >= sel_dd);
        quo  <= 64'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        case (unit)
          UNIT_MUL: acc <= acc + ({64'd0, pp} << shamt);
          UNIT_SQRT: begin
            srem <= sge ? srem2 - trial : srem2;
            root <= {root[62:0], sge};
            rad  <= rad << 2;
          end
          default: begin
            drem <= dge ? 64'(drem2 - {1'b0, dd}) : drem2[63:0];
            quo  <= {quo[62:0], dge};
            dnl  <= dnl << 1;
          end
        endcase
        if ((unit == UNIT_MUL) ? (cnt == 6'd3) : (cnt == 6'd63)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end

      if (fin) begin
        case (cmd.op)
          OP_MUL_AA:   t   <= acc;
          OP_MUL_BB:   t   <= t + acc;
          OP_SQRT_R:   r   <= root_g;
          OP_DIV_UX:   ux  <= div_res;
          OP_DIV_UY:   uy  <= div_res;
          OP_MUL_RR:   den <= acc[63:0];
          OP_MUL_GM:   gm  <= acc[63:0];
          OP_MUL_GMM:  t   <= s ? acc << (2 * FRAC_BITS - 2) : acc << (2 * FRAC_BITS);
          OP_DIV_M:    m   <= div_res;
          OP_MUL_MX:   sx  <= sat_add(sx, scale_unit(acc), dneg);
          OP_MUL_MY:   sy  <= sat_add(sy, scale_unit(acc), eneg);
          OP_MUL_XX:   t   <= acc;
          OP_MUL_YY:   t   <= t + acc;
          OP_MUL_LL: begin
            clamped <= (t > acc);
            mx      <= ax;
            my      <= ay;
          end
          OP_SQRT_MAG: mag <= root_g;
          OP_MUL_XL:   t2  <= acc;
          OP_DIV_X:    mx  <= div_res;
          OP_MUL_YL:   t2  <= acc;
          OP_DIV_Y:    my  <= div_res;
          default: begin
          end
        endcase
      end

      if (cmd.emit) begin
        force_x     <= out48(mx, sx[63]);
        force_y     <= out48(my, sy[63]);
        was_clamped <= clamped;
        sx          <= 64'd0;
        sy          <= 64'd0;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.done      = fin;
  assign stat.pair_zero = pz;
  assign stat.last      = last;
  assign stat.clamped   = clamped;
  assign stat.out_free  = !out_valid || out_ready;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.start |-> !busy)
    else $error("unit started while busy");
  a_fin_after_busy: assert property (@(posedge clk) disable iff (rst) fin |-> $past(busy))
    else $error("unit finished without running");
  a_load_idle: assert property (@(posedge clk) disable iff (rst) cmd.load |-> !busy && !fin)
    else $error("request loaded during computation");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

// File: rtl/gravity_force_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_force_accumulator
// Direct-sum 2D gravitational force on one target body, clamped on output.
// ----------------------------------------------------------------------------
// One request at a time. A pair request runs a decode step, then seven
// products on the shared 64x64 multiplier, one square root and three
// quotients, each unit started and finished in turn. A self pair skips
// them. A request marked last then adds the clamp check (three products,
// the check and the emit) and, when the limit is exceeded, one more root
// and two more products and divides. A finished result waits in the output
// register while the next request is taken.
module gravity_force_accumulator import gfa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   self_x,
  input  logic signed [31:0]   self_y,
  input  logic        [23:0]   self_mass,
  input  logic signed [31:0]   other_x,
  input  logic signed [31:0]   other_y,
  input  logic        [23:0]   other_mass,
  input  logic                 last_body,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [47:0]   force_x,
  output logic signed [47:0]   force_y,
  output logic                 was_clamped,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]          cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gfa_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  gfa_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .self_x      (self_x),
    .self_y      (self_y),
    .self_mass   (self_mass),
    .other_x     (other_x),
    .other_y     (other_y),
    .other_mass  (other_mass),
    .last_body   (last_body),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .force_x     (force_x),
    .force_y     (force_y),
    .was_clamped (was_clamped)
  );

endmodule

// File: tb/gravity_force_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_force_accumulator_tb
// Streams body pairs into the force accumulator under random backpressure,
// predicts every clamped force vector in fixed point and compares each
// returned result field by field. Covers self pairs, saturation, zero and
// maximum limits, and register writes between phases.
// ----------------------------------------------------------------------------
module gravity_force_accumulator_tb;
  import gfa_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 800;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN = 8'd2;

  typedef struct {
    logic signed [31:0] sx, sy, ox, oy;
    logic        [23:0] sm, om;
    logic               last;
  } pair_t;

  typedef struct {
    logic [47:0] fx, fy;
    logic        clamped;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] self_x = '0, self_y = '0, other_x = '0, other_y = '0;
  logic [23:0] self_mass = '0, other_mass = '0;
  logic last_body = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] force_x, force_y;
  logic was_clamped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRAV;
  logic [39:0] cfg_data = '0;

  // predictor state
  logic [31:0] grav = GRAV_RESET;
  logic [39:0] limit = LIMIT_RESET;
  logic signed [63:0] acc_x = '0, acc_y = '0;
  force_t expected_forces[$];
  int fail_count = 0;
  int snd_idle = 0;
  int rcv_idle = 0;

  gravity_force_accumulator #(.FRAC_BITS(FRAC)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [63:0] d);
    logic [127:0] q;
    q = n / 128'(d);
    return (q[127:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic logic signed [63:0] acc_add(input logic signed [63:0] acc,
                                                 input logic [63:0] m, input logic neg);
    logic [64:0] r;
    r = neg ? ({acc[63], acc} - {1'b0, m}) : ({acc[63], acc} + {1'b0, m});
    if (r[64] != r[63]) return neg ? MIN_S64 : MAX_S64;
    return r[63:0];
  endfunction

  function automatic logic [63:0] unit_scale(input logic [63:0] m, input logic [63:0] u);
    logic [127:0] p;
    p = 128'(m) * 128'(u);
    if (p[127:95] != '0) return MAX_S64;
    return p[95:32];
  endfunction

  function automatic logic [47:0] to48(input logic [63:0] m, input logic neg);
    logic [63:0] mm;
    if (neg) begin
      mm = (m > MIN_M48) ? MIN_M48 : m;
      return 48'd0 - mm[47:0];
    end
    mm = (m > MAX_S48) ? MAX_S48 : m;
    return mm[47:0];
  endfunction

  // adds one pair to the running sum, queues the clamped force on the last body
  task automatic predict_force(input pair_t p);
    logic signed [32:0] d, e;
    logic [32:0] a, b;
    logic s;
    logic [63:0] a64, b64, r, ux, uy, m, ax, ay, lim, mag, mx, my;
    logic [127:0] gm, ssq;
    force_t f;
    d = {p.sx[31], p.sx} - {p.ox[31], p.ox};
    e = {p.sy[31], p.sy} - {p.oy[31], p.oy};
    if (d != 0 || e != 0) begin
      a = d[32] ? -d : d;
      b = e[32] ? -e : e;
      s = a[32] | a[31] | b[32] | b[31];
      a64 = 64'(a >> s);
      b64 = 64'(b >> s);
      r = isqrt(128'(a64 * a64 + b64 * b64));
      if (r == 0) r = 1;
      ux = (a64 << 32) / r;
      uy = (b64 << 32) / r;
      gm = 128'(grav) * 128'(p.sm) * 128'(p.om);
      gm = gm << (2 * FRAC - 2 * s);
      m = div_sat(gm, r * r);
      acc_x = acc_add(acc_x, unit_scale(m, ux), d[32]);
      acc_y = acc_add(acc_y, unit_scale(m, uy), e[32]);
    end
    if (p.last) begin
      ax = acc_x[63] ? -acc_x : acc_x;
      ay = acc_y[63] ? -acc_y : acc_y;
      lim = 64'(limit) << FRAC;
      ssq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      mx = ax;
      my = ay;
      f.clamped = 1'b0;
      if (ssq > 128'(lim) * 128'(lim)) begin
        mag = isqrt(ssq);
        if (mag == 0) mag = 1;
        mx = div_sat(128'(ax) * 128'(lim), mag);
        my = div_sat(128'(ay) * 128'(lim), mag);
        f.clamped = 1'b1;
      end
      f.fx = to48(mx, acc_x[63]);
      f.fy = to48(my, acc_y[63]);
      expected_forces.push_back(f);
      acc_x = '0;
      acc_y = '0;
    end
  endtask

  task automatic send_pair(input pair_t p);
    in_valid <= 1'b1;
    self_x <= p.sx;
    self_y <= p.sy;
    self_mass <= p.sm;
    other_x <= p.ox;
    other_y <= p.oy;
    other_mass <= p.om;
    last_body <= p.last;
    do @(posedge clk); while (!in_ready);
    predict_force(p);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 400 : 4)) @(posedge clk);
    end
  endtask

  // hold off new requests until every expected force has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [39:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRAV) grav = data[31:0];
    else if (idx == CFG_LIMIT) limit = data;
    @(posedge clk);
  endtask

  function automatic pair_t mk(input logic signed [31:0] sx, sy, ox, oy,
                               input logic [23:0] sm, om, input logic last);
    pair_t p;
    p.sx = sx; p.sy = sy; p.ox = ox; p.oy = oy;
    p.sm = sm; p.om = om; p.last = last;
    return p;
  endfunction

  task automatic test_directed();
    send_pair(mk(32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd5, 24'd5, 1'b1));         // self pair
    send_pair(mk(32'sh10000, 32'sd0, 32'sd0, 32'sd0, 24'd10, 24'd20, 1'b1));   // x only
    send_pair(mk(32'sd7, -32'sh30000, 32'sd7, 32'sd0, 24'd300, 24'd9, 1'b1));  // y only
    send_pair(mk(32'sh7FFFFFFF, 32'sd0, 32'sh80000000, 32'sd0, '1, '1, 1'b1));
    send_pair(mk(32'sd0, 32'sh80000000, 32'sd0, 32'sh7FFFFFFF, '1, '1, 1'b1));
    send_pair(mk(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 '1, '1, 1'b1));
    send_pair(mk(32'sh123456, 32'sh654321, 32'sd0, 32'sd0, 24'd0, '1, 1'b1));  // zero mass
    // close heavy bodies on the same side saturate the sum
    send_pair(mk(32'sd1, 32'sd1, 32'sd0, 32'sd0, '1, '1, 1'b0));
    send_pair(mk(32'sd1, 32'sd1, 32'sd0, 32'sd0, '1, '1, 1'b0));
    send_pair(mk(32'sd1, 32'sd0, 32'sd0, 32'sd0, '1, '1, 1'b1));
    send_pair(mk(-32'sd1, -32'sd1, 32'sd0, 32'sd0, '1, '1, 1'b0));
    send_pair(mk(-32'sd1, -32'sd1, 32'sd0, 32'sd0, '1, '1, 1'b1));
    // several bodies, self pair in the middle, small force under the limit
    send_pair(mk(32'sh50000, 32'sh50000, 32'sh10000000, 32'sd0, 24'd2, 24'd3, 1'b0));
    send_pair(mk(32'sh50000, 32'sh50000, 32'sh50000, 32'sh50000, 24'd2, 24'd3, 1'b0));
    send_pair(mk(32'sh50000, 32'sh50000, 32'sd0, -32'sh10000000, 24'd2, 24'd7, 1'b1));
    drain();
  endtask

  task automatic test_limit_extremes();
    write_reg(CFG_LIMIT, 40'd0);
    send_pair(mk(32'sh20000, -32'sh20000, 32'sd0, 32'sd0, 24'd100, 24'd100, 1'b1));
    send_pair(mk(32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd100, 24'd100, 1'b1));
    drain();
    write_reg(CFG_LIMIT, '1);
    write_reg(CFG_GRAV, 40'hFF_FFFF_FFFF);
    write_reg(CFG_UNKNOWN, 40'd12345);   // ignored
    send_pair(mk(32'sd1, 32'sd3, 32'sd0, 32'sd0, '1, '1, 1'b1));
    send_pair(mk(32'sh1000000, 32'sd0, 32'sd0, 32'sd0, 24'd1, 24'd1, 1'b1));
    drain();
    write_reg(CFG_GRAV, 40'd0);
    send_pair(mk(32'sd1, 32'sd1, 32'sd0, 32'sd0, '1, '1, 1'b1));
    drain();
  endtask

  function automatic logic [23:0] rand_mass();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(1000));
      2: return '1;
      default: return 24'($urandom_range(1, 60000));
    endcase
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] v);
    int sh;
    sh = $urandom_range(4, 24);
    return v + 32'(($urandom & ((32'd1 << sh) - 1)) - (32'd1 << (sh - 1)));
  endfunction

  // groups of bodies around one random target, half of them near, others far or coincident
  task automatic test_random(input int count);
    pair_t p;
    int n, bodies, paused;
    n = 0;
    paused = 0;
    while (n < count) begin
      p.sx = ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 2000000));
      p.sy = ($urandom_range(1) == 0) ? 32'($urandom) : -32'($urandom_range(0, 2000000));
      p.sm = rand_mass();
      bodies = $urandom_range(1, 6);
      for (int k = 0; k < bodies; k++) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            p.ox = 32'($urandom);
            p.oy = 32'($urandom);
          end
          3, 4, 5: begin
            p.ox = near(p.sx);
            p.oy = near(p.sy);
          end
          6: begin
            p.ox = p.sx;
            p.oy = p.sy;
          end
          7: begin
            p.ox = p.sx;
            p.oy = near(p.sy);
          end
          8: begin
            p.ox = near(p.sx);
            p.oy = p.sy;
          end
          default: begin
            p.ox = ~p.sx;
            p.oy = ~p.sy;
          end
        endcase
        p.om = rand_mass();
        p.last = (k == bodies - 1);
        send_pair(p);
        n++;
      end
      if (!paused && n > count / 2) begin
        paused = 1;
        drain();
      end
    end
    drain();
  endtask

  task automatic test_idle_mode(input int s_idle, input int r_idle);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    write_reg(CFG_GRAV, 40'(GRAV_RESET));
    write_reg(CFG_LIMIT, 40'($urandom_range(1, 1000000)));
    test_random(150);
    write_reg(CFG_GRAV, 40'($urandom));
    write_reg(CFG_LIMIT, ($urandom_range(1) == 0) ? 40'(LIMIT_RESET)
                                                  : {8'($urandom), 32'($urandom)});
    test_random(150);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    force_t f;
    if (!rst && out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected force result x=%0d y=%0d", force_x, force_y);
        fail_count++;
      end else begin
        f = expected_forces.pop_front();
        if (force_x !== f.fx) begin
          $error("force_x expected %0d got %0d", $signed(f.fx), force_x);
          fail_count++;
        end
        if (force_y !== f.fy) begin
          $error("force_y expected %0d got %0d", $signed(f.fy), force_y);
          fail_count++;
        end
        if (was_clamped !== f.clamped) begin
          $error("was_clamped expected %0b got %0b", f.clamped, was_clamped);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    snd_idle = 33;
    rcv_idle = 60;
    test_directed();
    test_limit_extremes();
    test_idle_mode(33, 60);
    test_idle_mode(60, 33);
    test_idle_mode(0, 0);
    if (fail_count == 0 && expected_forces.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
